// File: hw/rtl/csma_backoff_controller_defines.svh
// Assertion macros for the CSMA backoff controller.
`ifndef CSMA_BACKOFF_CONTROLLER_DEFINES_SVH
`define CSMA_BACKOFF_CONTROLLER_DEFINES_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication, sampled on clk, off during reset
`define CSMA_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("csma assertion failed");

// next-cycle implication, sampled on clk, off during reset
`define CSMA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("csma assertion failed");

`else

`define CSMA_ASSERT_NOW(label, ante, cons)
`define CSMA_ASSERT_NEXT(label, ante, cons)

`endif

`endif

// File: hw/rtl/csma_pkg.sv
// Types and codes shared by the CSMA backoff controller modules.
`timescale 1ns / 1ps

package csma_pkg;

    // commands
    localparam logic [2:0] CMD_START        = 3'd0;
    localparam logic [2:0] CMD_CAD_BEGIN    = 3'd1;
    localparam logic [2:0] CMD_CAD_COMPLETE = 3'd2;
    localparam logic [2:0] CMD_TX_COMPLETE  = 3'd3;
    localparam logic [2:0] CMD_CANCEL       = 3'd4;
    localparam logic [2:0] CMD_RESET        = 3'd5;

    // channel check outcomes
    localparam logic [1:0] CAD_DONE    = 2'd0;
    localparam logic [1:0] CAD_TIMEOUT = 2'd1;
    localparam logic [1:0] CAD_FAILED  = 2'd2;
    localparam logic [1:0] CAD_BAD     = 2'd3;

    // status codes
    localparam logic [3:0] ST_OK          = 4'd0;
    localparam logic [3:0] ST_BACKOFF     = 4'd1;
    localparam logic [3:0] ST_TX_ALLOWED  = 4'd2;
    localparam logic [3:0] ST_BUSY        = 4'd3;
    localparam logic [3:0] ST_TIMEOUT     = 4'd4;
    localparam logic [3:0] ST_EXHAUSTED   = 4'd5;
    localparam logic [3:0] ST_CANCELLED   = 4'd6;
    localparam logic [3:0] ST_INVALID     = 4'd7;
    localparam logic [3:0] ST_ALREADY     = 4'd8;
    localparam logic [3:0] ST_WRONG_PHASE = 4'd9;
    localparam logic [3:0] ST_OVERFLOW    = 4'd10;
    localparam logic [3:0] ST_RNG_FAIL    = 4'd11;
    localparam logic [3:0] ST_CAD_FAIL    = 4'd12;
    localparam logic [3:0] ST_TX_FAIL     = 4'd13;

    // phases
    localparam logic [2:0] PH_IDLE      = 3'd0;
    localparam logic [2:0] PH_BACKOFF   = 3'd1;
    localparam logic [2:0] PH_CAD       = 3'd2;
    localparam logic [2:0] PH_TX        = 3'd3;
    localparam logic [2:0] PH_ERROR     = 3'd4;
    localparam logic [2:0] PH_EXHAUSTED = 3'd5;
    localparam logic [2:0] PH_CANCELLED = 3'd6;

    // last error
    localparam logic [2:0] ER_NONE     = 3'd0;
    localparam logic [2:0] ER_RNG      = 3'd1;
    localparam logic [2:0] ER_OVERFLOW = 3'd2;
    localparam logic [2:0] ER_CAD      = 3'd3;
    localparam logic [2:0] ER_TX       = 3'd4;

    // config register indexes
    localparam logic [1:0] REG_MAX_EXPONENT = 2'd0;
    localparam logic [1:0] REG_RETRY_LIMIT  = 2'd1;
    localparam logic [1:0] REG_BACKOFF_UNIT = 2'd2;

    localparam logic [4:0]  MAX_EXPONENT_RST = 5'd8;
    localparam logic [7:0]  RETRY_LIMIT_RST  = 8'd5;
    localparam logic [15:0] BACKOFF_UNIT_RST = 16'd10;

    typedef struct packed {
        logic [2:0] phase;
        logic [4:0] exponent;
        logic [7:0] retries;
        logic [2:0] err_code;
        logic       cancel;
    } csma_state_t;

    typedef struct packed {
        logic [4:0]  max_exponent;
        logic [7:0]  retry_limit;
        logic [15:0] backoff_unit;
    } csma_cfg_t;

endpackage

// File: hw/rtl/csma_core.sv
// Next-state and result logic for one command word, with the backoff draw.
`timescale 1ns / 1ps

module csma_core
    import csma_pkg::*;
(
    input  csma_state_t cur,
    input  csma_cfg_t   cfg,
    input  logic [2:0]  cmd,
    input  logic [4:0]  start_exp,
    input  logic [31:0] rand_word,
    input  logic        random_failed,
    input  logic [1:0]  cad_outcome,
    input  logic        busy_seen,
    input  logic        tx_failed,
    output csma_state_t nxt,
    output logic [3:0]  status,
    output logic [31:0] backoff_time
);

    logic [4:0]  e_inc;
    logic [4:0]  e_draw;
    logic [31:0] slots;
    logic [47:0] prod;
    logic [3:0]  draw_st;
    logic [31:0] draw_ms;
    logic [2:0]  draw_err;
    logic [8:0]  r_wide;
    logic [7:0]  r_sat;

    assign e_inc  = (cur.exponent < cfg.max_exponent) ? cur.exponent + 5'd1 : cur.exponent;
    assign e_draw = (cmd == CMD_START) ? start_exp : e_inc;

    // top e bits of the random word, then slots * unit
    assign slots = rand_word >> (6'd32 - {1'b0, e_draw});
    assign prod  = 48'(slots) * 48'(cfg.backoff_unit);

    always_comb
    begin
        draw_st = ST_OK;
        draw_ms = '0;
        priority if (e_draw > cfg.max_exponent)
        begin
            draw_st = ST_INVALID;
        end
        else if (e_draw == 5'd0)
        begin
            draw_st = ST_OK;
        end
        else if (random_failed)
        begin
            draw_st = ST_RNG_FAIL;
        end
        else if (cfg.backoff_unit == 16'd0)
        begin
            draw_st = ST_OK;
        end
        else if (prod[47:32] != 16'd0)
        begin
            draw_st = ST_OVERFLOW;
        end
        else
        begin
            draw_ms = prod[31:0];
        end
    end

    always_comb
    begin
        priority if (draw_st == ST_RNG_FAIL)
        begin
            draw_err = ER_RNG;
        end
        else if (draw_st == ST_OVERFLOW)
        begin
            draw_err = ER_OVERFLOW;
        end
        else
        begin
            draw_err = ER_NONE;
        end
    end

    assign r_wide = {1'b0, cur.retries} + 9'd1;
    assign r_sat  = r_wide[8] ? 8'hFF : r_wide[7:0];

    always_comb
    begin
        nxt          = cur;
        status       = ST_INVALID;
        backoff_time = '0;
        unique case (cmd)
            CMD_START:
            begin
                priority if (start_exp > cfg.max_exponent)
                begin
                    status = ST_INVALID;
                end
                else if (cur.phase == PH_BACKOFF || cur.phase == PH_CAD || cur.phase == PH_TX)
                begin
                    status = ST_ALREADY;
                end
                else
                begin
                    nxt.cancel = 1'b0;
                    if (draw_st != ST_OK)
                    begin
                        status       = draw_st;
                        nxt.phase    = PH_ERROR;
                        nxt.err_code = draw_err;
                    end
                    else
                    begin
                        status       = ST_BACKOFF;
                        backoff_time = draw_ms;
                        nxt.phase    = PH_BACKOFF;
                        nxt.err_code = ER_NONE;
                        nxt.exponent = start_exp;
                        nxt.retries  = '0;
                    end
                end
            end
            CMD_CAD_BEGIN:
            begin
                priority if (cur.cancel)
                begin
                    status       = ST_CANCELLED;
                    nxt.phase    = PH_CANCELLED;
                    nxt.err_code = ER_NONE;
                end
                else if (cur.phase != PH_BACKOFF)
                begin
                    status = ST_WRONG_PHASE;
                end
                else
                begin
                    status    = ST_OK;
                    nxt.phase = PH_CAD;
                end
            end
            CMD_CAD_COMPLETE:
            begin
                priority if (cad_outcome == CAD_BAD)
                begin
                    status = ST_INVALID;
                end
                else if (cur.cancel)
                begin
                    status       = ST_CANCELLED;
                    nxt.phase    = PH_CANCELLED;
                    nxt.err_code = ER_NONE;
                end
                else if (cur.phase != PH_CAD)
                begin
                    status = ST_WRONG_PHASE;
                end
                else if (cad_outcome == CAD_FAILED)
                begin
                    status       = ST_CAD_FAIL;
                    nxt.phase    = PH_ERROR;
                    nxt.err_code = ER_CAD;
                end
                else if (cad_outcome == CAD_DONE && !busy_seen)
                begin
                    status       = ST_TX_ALLOWED;
                    nxt.phase    = PH_TX;
                    nxt.err_code = ER_NONE;
                    nxt.exponent = '0;
                    nxt.retries  = '0;
                end
                else if (r_wide > {1'b0, cfg.retry_limit})
                begin
                    status       = ST_EXHAUSTED;
                    nxt.phase    = PH_EXHAUSTED;
                    nxt.err_code = ER_NONE;
                    nxt.retries  = r_sat;
                end
                else if (draw_st != ST_OK)
                begin
                    status       = draw_st;
                    nxt.phase    = PH_ERROR;
                    nxt.err_code = draw_err;
                end
                else
                begin
                    status       = (cad_outcome == CAD_TIMEOUT) ? ST_TIMEOUT : ST_BUSY;
                    backoff_time = draw_ms;
                    nxt.phase    = PH_BACKOFF;
                    nxt.err_code = ER_NONE;
                    nxt.exponent = e_inc;
                    nxt.retries  = r_sat;
                end
            end
            CMD_TX_COMPLETE:
            begin
                priority if (cur.cancel)
                begin
                    status       = ST_CANCELLED;
                    nxt.phase    = PH_CANCELLED;
                    nxt.err_code = ER_NONE;
                end
                else if (cur.phase != PH_TX)
                begin
                    status = ST_WRONG_PHASE;
                end
                else if (tx_failed)
                begin
                    status       = ST_TX_FAIL;
                    nxt.phase    = PH_ERROR;
                    nxt.err_code = ER_TX;
                end
                else
                begin
                    status       = ST_OK;
                    nxt.phase    = PH_IDLE;
                    nxt.err_code = ER_NONE;
                end
            end
            CMD_CANCEL:
            begin
                status       = ST_OK;
                nxt.cancel   = 1'b1;
                nxt.phase    = PH_CANCELLED;
                nxt.err_code = ER_NONE;
            end
            CMD_RESET:
            begin
                status       = ST_OK;
                nxt.cancel   = 1'b0;
                nxt.phase    = PH_IDLE;
                nxt.err_code = ER_NONE;
                nxt.exponent = '0;
                nxt.retries  = '0;
            end
            default:
            begin
                status = ST_INVALID;
            end
        endcase
    end

endmodule

// File: hw/rtl/csma_backoff_controller.sv
// Top level of the CSMA backoff controller: input word register, state, result register.
//
//  channel  dir  width  fields
//  s_*      in   3+48   tuser: cmd; tdata: command operands
//  m_*      out  4+56   tuser: status; tdata: backoff time and state after the word
//  cfg_*    in   2+16   register write, no read-back
//
//  One word per cycle unless m_tready stalls; input register, then result register.
//  The rate is set by the combinational path shift + 32x16 multiply + state update.
//  rst_n is asynchronous: idle phase, zero state, register defaults, both stages empty.
//  A stalled result stage holds its word; the input stage refills as it drains.
`timescale 1ns / 1ps
`include "csma_backoff_controller_defines.svh"

module csma_backoff_controller
    import csma_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [4:0] start_exp, [36:5] rand_word, [37] random_failed,
    // [39:38] cad_outcome, [40] busy_seen, [41] tx_failed, [47:42] zero
    input  logic [47:0] s_tdata,
    // [2:0] cmd
    input  logic [2:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [31:0] backoff_time, [34:32] phase_now, [39:35] exponent_now,
    // [47:40] retries_now, [50:48] error_now, [51] cancel_flag, [55:52] zero
    output logic [55:0] m_tdata,
    // [3:0] status
    output logic [3:0]  m_tuser,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    logic        in_valid_reg;
    logic [2:0]  in_cmd_reg;
    logic [41:0] in_data_reg;
    logic        out_valid_reg;
    logic [3:0]  out_status_reg;
    logic [31:0] out_time_reg;
    csma_state_t state_reg;
    csma_state_t state_next;
    csma_cfg_t   cfg_reg;
    logic [3:0]  step_status;
    logic [31:0] step_time;
    logic        advance;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.max_exponent <= MAX_EXPONENT_RST;
            cfg_reg.retry_limit  <= RETRY_LIMIT_RST;
            cfg_reg.backoff_unit <= BACKOFF_UNIT_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_MAX_EXPONENT: cfg_reg.max_exponent <= cfg_data[4:0];
                REG_RETRY_LIMIT:  cfg_reg.retry_limit  <= cfg_data[7:0];
                REG_BACKOFF_UNIT: cfg_reg.backoff_unit <= cfg_data;
                default:          cfg_reg              <= cfg_reg;
            endcase
        end
    end

    csma_core u_core (
        .cur           (state_reg),
        .cfg           (cfg_reg),
        .cmd           (in_cmd_reg),
        .start_exp     (in_data_reg[4:0]),
        .rand_word     (in_data_reg[36:5]),
        .random_failed (in_data_reg[37]),
        .cad_outcome   (in_data_reg[39:38]),
        .busy_seen     (in_data_reg[40]),
        .tx_failed     (in_data_reg[41]),
        .nxt           (state_next),
        .status        (step_status),
        .backoff_time  (step_time)
    );

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '{phase: PH_IDLE, exponent: 5'd0, retries: 8'd0,
                               err_code: ER_NONE, cancel: 1'b0};
        end
        else
        begin
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
                state_reg     <= state_next;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_cmd_reg  <= s_tuser;
            in_data_reg <= s_tdata[41:0];
        end
        if (advance)
        begin
            out_status_reg <= step_status;
            out_time_reg   <= step_time;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tdata  = {4'd0, state_reg.cancel, state_reg.err_code, state_reg.retries,
                       state_reg.exponent, state_reg.phase, out_time_reg};

    `CSMA_ASSERT_NOW(a_cancel_phase, state_reg.cancel, state_reg.phase == PH_CANCELLED)
    `CSMA_ASSERT_NOW(a_error_phase, state_reg.err_code != ER_NONE, state_reg.phase == PH_ERROR)
    `CSMA_ASSERT_NOW(a_tx_clean, state_reg.phase == PH_TX,
        state_reg.exponent == 5'd0 && state_reg.retries == 8'd0)
    `CSMA_ASSERT_NOW(a_time_only_on_draw, out_valid_reg && out_time_reg != 32'd0,
        out_status_reg == ST_BACKOFF || out_status_reg == ST_BUSY ||
        out_status_reg == ST_TIMEOUT)
    `CSMA_ASSERT_NEXT(a_state_holds, !advance, $stable(state_reg))

endmodule
